[rtl/kick_drum_voice_defines.svh]
// Assertion helpers for the kick drum voice
`ifndef KICK_DRUM_VOICE_DEFINES_SVH
`define KICK_DRUM_VOICE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KDV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define KDV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KDV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define KDV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/kdv_pkg.sv]
package kdv_pkg;

    localparam int PHASE_BITS      = 24;
    localparam int SINE_TABLE_BITS = 10;
    localparam int OUT_BITS        = 16;

    localparam int REG_W     = 24;
    localparam int ENV_W     = 24;
    localparam int CFG_IDX_W = 4;
    localparam int TBL_N     = 1 << SINE_TABLE_BITS;
    localparam int ADDR_W    = SINE_TABLE_BITS + 1;
    localparam int MAG_W     = OUT_BITS - 1;
    localparam int OUT_MAX   = (1 << (OUT_BITS - 1)) - 1;
    localparam int SWEEP_W   = 2 * REG_W - 23;
    localparam int ADD_W     = ((PHASE_BITS > SWEEP_W) ? PHASE_BITS : SWEEP_W) + 2;

    localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(1 << 23);

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_DECAY   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_DECAY = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_STEP   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_STEP  = CFG_IDX_W'(3);

    localparam logic [REG_W-1:0] AMP_DECAY_RST   = REG_W'(874);
    localparam logic [REG_W-1:0] PITCH_DECAY_RST = REG_W'(6991);
    localparam logic [REG_W-1:0] BASE_STEP_RST   = REG_W'(17476);
    localparam logic [REG_W-1:0] SWEEP_STEP_RST  = REG_W'(34953);

    typedef struct packed {
        logic             action;
        logic [ENV_W-1:0] velocity;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] sample;
        logic                       voice_active;
    } out_item_t;

    typedef struct packed {
        logic [REG_W-1:0] amp_decay_step;
        logic [REG_W-1:0] pitch_decay_step;
        logic [REG_W-1:0] base_phase_step;
        logic [REG_W-1:0] sweep_phase_step;
    } cfg_t;

    // table lookup request
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              neg;
        logic              act;
        logic              voice_active;
        logic [ENV_W-1:0]  amp;
    } lookup_t;

    // scaling request
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             act;
        logic             voice_active;
        logic [ENV_W-1:0] amp;
    } scale_t;

    typedef logic [MAG_W-1:0] qsine_t [0:TBL_N];

    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        return (x * t) >> 30;
    endfunction

    function automatic qsine_t build_qsine();
        qsine_t      tbl;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] v;
        for (int i = 0; i <= TBL_N; i++) begin
            x = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
            s = sin_q30(x);
            v = (s * 64'(OUT_MAX) + (Q30_ONE >> 1)) >> 30;
            if (v > 64'(OUT_MAX)) begin
                v = 64'(OUT_MAX);
            end
            tbl[i] = MAG_W'(v);
        end
        return tbl;
    endfunction

    localparam qsine_t QSINE = build_qsine();

endpackage

[rtl/kdv_cfg_regs.sv]
module kdv_cfg_regs
    import kdv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.amp_decay_step   <= AMP_DECAY_RST;
            cfg_reg.pitch_decay_step <= PITCH_DECAY_RST;
            cfg_reg.base_phase_step  <= BASE_STEP_RST;
            cfg_reg.sweep_phase_step <= SWEEP_STEP_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_AMP_DECAY:   cfg_reg.amp_decay_step   <= cfg_data;
                CFG_PITCH_DECAY: cfg_reg.pitch_decay_step <= cfg_data;
                CFG_BASE_STEP:   cfg_reg.base_phase_step  <= cfg_data;
                CFG_SWEEP_STEP:  cfg_reg.sweep_phase_step <= cfg_data;
                default: ;  // drop writes past the register list
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/kdv_voice_core.sv]
`include "kick_drum_voice_defines.svh"

module kdv_voice_core
    import kdv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     lk_valid,
    input  logic     lk_ready,
    output lookup_t  lk_data
);

    logic                  snd_reg;
    logic [ENV_W-1:0]      amp_reg;
    logic [ENV_W-1:0]      pitch_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic                  lk_valid_reg;
    lookup_t               lk_reg;

    logic                  accept;
    logic [ENV_W-1:0]      vel_sat;
    logic                  snd_eff;
    logic [ENV_W-1:0]      amp_eff;
    logic [ENV_W-1:0]      pitch_eff;
    logic [PHASE_BITS-1:0] phase_eff;
    logic [2*REG_W-1:0]    sweep_prod;
    logic [SWEEP_W-1:0]    sweep_term;
    logic [ADD_W-1:0]      phase_sum;
    logic                  amp_end;
    logic [ENV_W-1:0]      amp_next;
    logic [ENV_W-1:0]      pitch_next;
    logic                  snd_next;
    logic [1:0]            quad;
    logic [ADDR_W-1:0]     k_ext;
    lookup_t               lk_next;

    assign s_ready = !lk_valid_reg || lk_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        vel_sat   = (s_data.velocity > ENV_ONE) ? ENV_ONE : s_data.velocity;
        // a trigger restarts the voice before this tick's sample
        snd_eff   = s_data.action || snd_reg;
        amp_eff   = s_data.action ? vel_sat : amp_reg;
        pitch_eff = s_data.action ? ENV_ONE : pitch_reg;
        phase_eff = s_data.action ? '0 : phase_reg;

        sweep_prod = (2*REG_W)'(pitch_eff) * (2*REG_W)'(cfg.sweep_phase_step);
        sweep_term = sweep_prod[2*REG_W-1:23];
        phase_sum  = ADD_W'(phase_eff) + ADD_W'(cfg.base_phase_step) + ADD_W'(sweep_term);

        amp_end    = amp_eff <= cfg.amp_decay_step;
        amp_next   = amp_end ? '0 : amp_eff - cfg.amp_decay_step;
        pitch_next = (pitch_eff <= cfg.pitch_decay_step) ? '0
                                                         : pitch_eff - cfg.pitch_decay_step;
        snd_next   = snd_eff && !amp_end;

        quad  = phase_eff[PHASE_BITS-1 -: 2];
        k_ext = {1'b0, phase_eff[PHASE_BITS-3 -: SINE_TABLE_BITS]};

        // odd quadrants read the table backward
        lk_next.addr         = quad[0] ? ADDR_W'(TBL_N) - k_ext : k_ext;
        lk_next.neg          = quad[1];
        lk_next.act          = snd_eff;
        lk_next.voice_active = snd_next;
        lk_next.amp          = amp_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snd_reg   <= 1'b0;
            amp_reg   <= '0;
            pitch_reg <= '0;
            phase_reg <= '0;
        end else if (accept && snd_eff) begin
            snd_reg   <= snd_next;
            amp_reg   <= amp_next;
            pitch_reg <= pitch_next;
            phase_reg <= phase_sum[PHASE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lk_valid_reg <= 1'b0;
        end else if (s_ready) begin
            lk_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            lk_reg <= lk_next;
        end
    end

    assign lk_valid = lk_valid_reg;
    assign lk_data  = lk_reg;

    `KDV_ASSERT_NEXT(a_silent_hold, aclk, aresetn,
        accept && !s_data.action && !snd_reg,
        $stable(amp_reg) && $stable(pitch_reg) && $stable(phase_reg) && !snd_reg,
        "silent tick changed voice state")
    `KDV_ASSERT_NOW(a_amp_range, aclk, aresetn,
        snd_reg,
        amp_reg != '0 && amp_reg <= ENV_ONE,
        "sounding voice with amplitude out of range")

endmodule

[rtl/kdv_sine_rom.sv]
module kdv_sine_rom
    import kdv_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    lk_valid,
    output logic    lk_ready,
    input  lookup_t lk_data,
    output logic    sc_valid,
    input  logic    sc_ready,
    output scale_t  sc_data
);

    logic   sc_valid_reg;
    scale_t sc_reg;

    assign lk_ready = !sc_valid_reg || sc_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_valid_reg <= 1'b0;
        end else if (lk_ready) begin
            sc_valid_reg <= lk_valid;
        end
    end

    // registered read of the quarter-wave table
    always_ff @(posedge aclk) begin
        if (lk_valid && lk_ready) begin
            sc_reg.mag          <= QSINE[lk_data.addr];
            sc_reg.neg          <= lk_data.neg;
            sc_reg.act          <= lk_data.act;
            sc_reg.voice_active <= lk_data.voice_active;
            sc_reg.amp          <= lk_data.amp;
        end
    end

    assign sc_valid = sc_valid_reg;
    assign sc_data  = sc_reg;

endmodule

[rtl/kdv_out_stage.sv]
`include "kick_drum_voice_defines.svh"

module kdv_out_stage
    import kdv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      sc_valid,
    output logic      sc_ready,
    input  scale_t    sc_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int PROD_W = MAG_W + ENV_W + 1;

    logic                       m_valid_reg;
    out_item_t                  m_reg;
    logic                       load;
    logic [PROD_W-1:0]          prod;
    logic [OUT_BITS-1:0]        scaled;
    out_item_t                  m_next;

    assign sc_ready = !m_valid_reg || m_ready;
    assign load     = sc_valid && sc_ready;

    always_comb begin
        prod   = PROD_W'(sc_data.mag) * PROD_W'(sc_data.amp) + (PROD_W'(1) << 22);
        scaled = prod[23 +: OUT_BITS];
        if (!sc_data.act) begin
            m_next.sample = '0;
        end else if (sc_data.neg) begin
            m_next.sample = $signed(-scaled);
        end else begin
            m_next.sample = $signed(scaled);
        end
        m_next.voice_active = sc_data.voice_active;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (sc_ready) begin
            m_valid_reg <= sc_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_reg <= m_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_reg;

    `KDV_ASSERT_NEXT(a_silent_zero, aclk, aresetn,
        load && !sc_data.act,
        m_reg.sample == '0 && !m_reg.voice_active,
        "silent tick produced a nonzero sample")

endmodule

[rtl/kick_drum_voice.sv]
// Channel   | Handshake         | Payload                        | Direction
// ----------+-------------------+--------------------------------+----------
// s_        | s_valid / s_ready | in_item_t: action, velocity    | in
// m_        | m_valid / m_ready | out_item_t: sample, voice_active| out
// cfg_      | cfg_we            | cfg_index, cfg_data            | in
//
// One request per clock unless m_ready stalls; each result is held in lk, sc, then m.
// Envelope and phase update for a tick happens in the accept cycle, so ticks chain
// back to back; the sine table read and the amplitude multiply follow in two stages.
// Reset (synchronous, active low) silences the voice and loads default step values.
// Each stage holds while the one after it is full and stalled; s_ready drops only
// when every stage holds a request.
module kick_drum_voice
    import kdv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data
);

    cfg_t    cfg;
    logic    lk_valid;
    logic    lk_ready;
    lookup_t lk_data;
    logic    sc_valid;
    logic    sc_ready;
    scale_t  sc_data;

    kdv_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kdv_voice_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .lk_valid (lk_valid),
        .lk_ready (lk_ready),
        .lk_data  (lk_data)
    );

    kdv_sine_rom u_rom (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .lk_valid (lk_valid),
        .lk_ready (lk_ready),
        .lk_data  (lk_data),
        .sc_valid (sc_valid),
        .sc_ready (sc_ready),
        .sc_data  (sc_data)
    );

    kdv_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sc_valid (sc_valid),
        .sc_ready (sc_ready),
        .sc_data  (sc_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

[tb/tb_top.sv]
module tb_top;
    import kdv_pkg::*;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_TRIG = 1'b1;

    localparam bit [63:0] UNITY_Q30   = 64'd1 << 30;
    localparam bit [63:0] QUARTER_ARC = 64'd1686629713;

    typedef struct packed {
        in_item_t  item;
        logic      known;
        out_item_t res;
    } tick_row_t;

    // hand-checked rows use the reset step values
    localparam tick_row_t DIRECTED_TICKS [22] = '{
        '{'{ACT_TICK, 24'h000000}, 1'b1, '{16'sd0, 1'b0}},
        '{'{ACT_TICK, 24'hFFFFFF}, 1'b1, '{16'sd0, 1'b0}},
        '{'{ACT_TRIG, 24'h000000}, 1'b1, '{16'sd0, 1'b0}},
        '{'{ACT_TICK, 24'h000000}, 1'b1, '{16'sd0, 1'b0}},
        '{'{ACT_TRIG, 24'h800000}, 1'b1, '{16'sd0, 1'b1}},
        '{'{ACT_TICK, 24'h000000}, 1'b0, '{16'sd0, 1'b0}},
        '{'{ACT_TICK, 24'hFFFFFF}, 1'b0, '{16'sd0, 1'b0}},
        '{'{ACT_TICK, 24'h000000}, 1'b0, '{16'sd0, 1'b0}},
        '{'{ACT_TICK, 24'h5A5A5A}, 1'b0, '{16'sd0, 1'b0}},
        '{'{ACT_TICK, 24'hA5A5A5}, 1'b0, '{16'sd0, 1'b0}},
        '{'{ACT_TRIG, 24'hFFFFFF}, 1'b1, '{16'sd0, 1'b1}},
        '{'{ACT_TICK, 24'h000000}, 1'b0, '{16'sd0, 1'b0}},
        '{'{ACT_TICK, 24'h000000}, 1'b0, '{16'sd0, 1'b0}},
        '{'{ACT_TICK, 24'h000000}, 1'b0, '{16'sd0, 1'b0}},
        '{'{ACT_TRIG, 24'h800001}, 1'b1, '{16'sd0, 1'b1}},
        '{'{ACT_TRIG, 24'd874},    1'b1, '{16'sd0, 1'b0}},
        '{'{ACT_TRIG, 24'd875},    1'b1, '{16'sd0, 1'b1}},
        '{'{ACT_TICK, 24'h000000}, 1'b0, '{16'sd0, 1'b0}},
        '{'{ACT_TRIG, 24'h555555}, 1'b1, '{16'sd0, 1'b1}},
        '{'{ACT_TICK, 24'h000000}, 1'b0, '{16'sd0, 1'b0}},
        '{'{ACT_TICK, 24'h000000}, 1'b0, '{16'sd0, 1'b0}},
        '{'{ACT_TICK, 24'h000000}, 1'b0, '{16'sd0, 1'b0}}
    };

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;

    kick_drum_voice DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // voice model state
    bit [MAG_W-1:0]      sine_lut [0:TBL_N];
    cfg_t                voice_regs = '{24'd874, 24'd6991, 24'd17476, 24'd34953};
    bit                  voice_on   = 1'b0;
    bit [ENV_W-1:0]      env_amp    = '0;
    bit [ENV_W-1:0]      env_pitch  = '0;
    bit [PHASE_BITS-1:0] phase_acc  = '0;

    out_item_t due_samples [$];
    int        mismatches   = 0;
    bit        in_idle      = 1'b1;
    bit        out_idle     = 1'b1;
    bit        hold_m_ready = 1'b0;

    function automatic bit [63:0] taylor_sin(input bit [63:0] x);
        bit [63:0] sq;
        bit [63:0] acc;
        int        divs [5];
        divs = '{110, 72, 42, 20, 6};
        sq   = (x * x) >> 30;
        acc  = UNITY_Q30;
        foreach (divs[j]) acc = UNITY_Q30 - ((sq * acc) >> 30) / divs[j];
        return (x * acc) >> 30;
    endfunction

    // one sample tick of the voice; advances the model state
    function automatic out_item_t voice_tick(input in_item_t it);
        out_item_t r;
        bit [1:0]  quad;
        bit [SINE_TABLE_BITS-1:0] k;
        bit [MAG_W-1:0] mag;
        bit [63:0] prod;
        bit [63:0] sweep;
        r = '0;
        if (it.action == ACT_TRIG) begin
            voice_on  = 1'b1;
            env_amp   = (it.velocity > ENV_ONE) ? ENV_ONE : it.velocity;
            env_pitch = ENV_ONE;
            phase_acc = '0;
        end
        if (voice_on) begin
            quad  = phase_acc[PHASE_BITS-1 -: 2];
            k     = phase_acc[PHASE_BITS-3 -: SINE_TABLE_BITS];
            mag   = quad[0] ? sine_lut[TBL_N - k] : sine_lut[k];
            prod  = (64'(mag) * 64'(env_amp) + (64'(ENV_ONE) >> 1)) >> 23;
            sweep = (64'(env_pitch) * 64'(voice_regs.sweep_phase_step)) >> 23;
            r.sample  = quad[1] ? OUT_BITS'(-prod) : OUT_BITS'(prod);
            phase_acc = PHASE_BITS'(64'(phase_acc) + 64'(voice_regs.base_phase_step) + sweep);
            if (env_amp <= voice_regs.amp_decay_step) begin
                env_amp  = '0;
                voice_on = 1'b0;
            end else begin
                env_amp = env_amp - voice_regs.amp_decay_step;
            end
            if (env_pitch <= voice_regs.pitch_decay_step) begin
                env_pitch = '0;
            end else begin
                env_pitch = env_pitch - voice_regs.pitch_decay_step;
            end
        end
        r.voice_active = voice_on;
        return r;
    endfunction

    function automatic in_item_t random_tick();
        in_item_t it;
        it.action = ($urandom_range(0, 19) == 0) ? ACT_TRIG : ACT_TICK;
        case ($urandom_range(0, 4))
            0: it.velocity = '0;
            1: it.velocity = ENV_ONE;
            2: it.velocity = ENV_W'($urandom_range(ENV_ONE + 1, 24'hFFFFFF));
            default: it.velocity = ENV_W'($urandom);
        endcase
        return it;
    endfunction

    function automatic cfg_t random_regs();
        cfg_t c;
        c.amp_decay_step   = REG_W'($urandom_range(1 << 16, 1 << 20));
        c.pitch_decay_step = REG_W'($urandom_range(0, 1 << 21));
        c.base_phase_step  = REG_W'($urandom);
        c.sweep_phase_step = REG_W'($urandom);
        return c;
    endfunction

    // all four step registers, then one write to an unused index
    task automatic load_regs(input cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_AMP_DECAY;
        cfg_data  <= c.amp_decay_step;
        @(posedge aclk);
        cfg_index <= CFG_PITCH_DECAY;
        cfg_data  <= c.pitch_decay_step;
        @(posedge aclk);
        cfg_index <= CFG_BASE_STEP;
        cfg_data  <= c.base_phase_step;
        @(posedge aclk);
        cfg_index <= CFG_SWEEP_STEP;
        cfg_data  <= c.sweep_phase_step;
        @(posedge aclk);
        cfg_index <= CFG_IDX_W'($urandom_range(CFG_SWEEP_STEP + 1, (1 << CFG_IDX_W) - 1));
        cfg_data  <= REG_W'($urandom);
        @(posedge aclk);
        cfg_we     <= 1'b0;
        voice_regs = c;
    endtask

    task automatic push_tick(input in_item_t it, input bit known, input out_item_t hand_res);
        int        gap;
        out_item_t r;
        gap = in_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        r = voice_tick(it);
        due_samples.push_back(known ? hand_res : r);
    endtask

    task automatic drain();
        while (due_samples.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        bit [63:0] x;
        bit [63:0] v;
        cfg_t      c;
        for (int i = 0; i <= TBL_N; i++) begin
            x = (QUARTER_ARC * 64'(i)) >> SINE_TABLE_BITS;
            v = (taylor_sin(x) * 64'(OUT_MAX) + (UNITY_Q30 >> 1)) >> 30;
            if (v > 64'(OUT_MAX)) v = 64'(OUT_MAX);
            sine_lut[i] = MAG_W'(v);
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_TICKS[i]) begin
            push_tick(DIRECTED_TICKS[i].item, DIRECTED_TICKS[i].known, DIRECTED_TICKS[i].res);
        end
        s_valid <= 1'b0;
        drain();

        for (int ph = 0; ph < 11; ph++) begin
            case (ph)
                0: c = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
                1: c = '{24'd0, 24'd0, 24'd0, 24'hFFFFFF};
                2: c = '{24'd1, 24'h800000, 24'h800000, 24'd0};
                default: c = random_regs();
            endcase
            load_regs(c);
            in_idle  = 1'($urandom_range(0, 1));
            out_idle = 1'($urandom_range(0, 1));
            // back up the output while requests keep coming
            if (ph == 5) begin
                in_idle      = 1'b0;
                hold_m_ready = 1'b1;
            end
            repeat (100) push_tick(random_tick(), 1'b0, '0);
            s_valid <= 1'b0;
            drain();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && due_samples.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = out_idle ? $urandom_range(0, 6) : 0;
            if (hold_m_ready) begin
                hold_m_ready = 1'b0;
                stall        = 150;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(negedge aclk);
            while (!(aresetn && m_valid)) @(negedge aclk);
            @(posedge aclk);
        end
    end

    // handshake signals are stable at the falling edge; the transfer lands on the next rise
    always @(negedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_samples.size() == 0) begin
                $display("%0t: result with none due: sample %0d active %0b",
                         $time, m_data.sample, m_data.voice_active);
                mismatches++;
            end else begin
                want = due_samples.pop_front();
                if (m_data.sample !== want.sample) begin
                    $display("%0t: sample expected %0d got %0d",
                             $time, want.sample, m_data.sample);
                    mismatches++;
                end
                if (m_data.voice_active !== want.voice_active) begin
                    $display("%0t: voice_active expected %0b got %0b",
                             $time, want.voice_active, m_data.voice_active);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
